FILE: hdl/hdw_pkg.sv
// ============================================================================
// hdw_pkg: shared definitions for the 2D Haar wavelet block
// Field widths, fixed-point constants, register indexes and the control
// state type used by the stream interfaces and the datapath.
// ============================================================================
package hdw_pkg;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEFF_W   = 25;
    localparam int COORD_W   = 6;
    localparam int HALF_W    = 6;
    localparam int CFG_IDX_W = 1;

    // Datapath widths: row-pass pair, column operand, column product
    localparam int PAIR_W  = 25;
    localparam int OP_W    = 26;
    localparam int PROD_W  = 34;
    localparam int FRAC_W  = 8;

    // 1/sqrt(2) in Q.8 and the half-LSB used for rounding
    localparam int SQRT_HALF_Q8 = 181;
    localparam int ROUND_HALF   = 128;

    // Largest size register value the counters support
    localparam int HALF_MAX = 32;

    // Default image bounds
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 1'b1;

    // Coefficient sequence within one 2x2 group
    localparam int          KIDX_W = 2;
    localparam logic [1:0]  LAST_K = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMB,
        S_EMIT
    } t_state;

endpackage

FILE: hdl/hdw_in_if.sv
// ============================================================================
// hdw_in_if: sample stream channel
// Valid/ready channel carrying one signed raster sample per transaction.
// ============================================================================
interface hdw_in_if;
    import hdw_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

FILE: hdl/hdw_out_if.sv
// ============================================================================
// hdw_out_if: coefficient stream channel
// Valid/ready channel carrying one coefficient and its position per
// transaction.
// ============================================================================
interface hdw_out_if;
    import hdw_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COEFF_W-1:0] coeff;
    logic [COORD_W-1:0]        out_col;
    logic [COORD_W-1:0]        out_row;
    logic                      run_last;

    modport source (output valid, output coeff, output out_col, output out_row,
                    output run_last, input ready);
    modport sink   (input valid, input coeff, input out_col, input out_row,
                    input run_last, output ready);

endinterface

FILE: hdl/haar_dwt_2d_single_level.sv
// ============================================================================
// haar_dwt_2d_single_level: one-level 2D Haar transform over a raster stream
// Rate: samples that produce no coefficient are taken one per cycle. An
// odd-row, odd-column sample starts the pair-store read, then operand build,
// then four coefficients at one per cycle unless the output stalls, with
// input held off from operand build until the fourth coefficient is loaded.
// Reset clears counters, output valid and sets sizes to 32; store kept as is.
// ============================================================================
module haar_dwt_2d_single_level #(
    parameter int MAX_WIDTH  = hdw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hdw_pkg::DEF_MAX_HEIGHT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hdw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hdw_pkg::HALF_W-1:0]     i_cfg_data,
    hdw_in_if.sink                         i_in,
    hdw_out_if.source                      o_out
);
    import hdw_pkg::*;

    // Effective size limits and pair store geometry
    localparam int W_LIM      = (MAX_WIDTH / 2 < HALF_MAX) ? MAX_WIDTH / 2 : HALF_MAX;
    localparam int H_LIM      = (MAX_HEIGHT / 2 < HALF_MAX) ? MAX_HEIGHT / 2 : HALF_MAX;
    localparam int PAIR_DEPTH = W_LIM;
    localparam int ADDR_W     = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int STORE_W    = 2 * PAIR_W;
    localparam int CNT_W      = COORD_W + 1;
    localparam int IDX_W      = COORD_W - 1;

    t_state r_state, n_state;

    logic [HALF_W-1:0]  r_half_w, r_half_h;
    logic [HALF_W-1:0]  w_hw, w_hh;
    logic [COORD_W-1:0] r_col, r_row;
    logic signed [SAMPLE_W-1:0] r_held;

    logic w_in_ready, w_in_acc, w_op_load, w_load;
    logic w_pair_end, w_ram_we, w_ram_re;

    logic [CNT_W-1:0] w_col_inc, w_row_inc;
    logic             w_col_wrap, w_row_wrap;

    logic signed [SAMPLE_W:0]  w_add, w_sub;
    logic signed [PAIR_W-1:0]  w_sum_q8, w_diff_q8;
    logic [ADDR_W-1:0]         w_addr;
    logic [STORE_W-1:0]        w_rdata;
    logic signed [PAIR_W-1:0]  w_st, w_dt;

    logic signed [PAIR_W-1:0]  r_sum, r_diff;
    logic [IDX_W-1:0]          r_i, r_j;
    logic signed [OP_W-1:0]    r_op [4];
    logic [KIDX_W-1:0]         r_k;

    logic signed [PROD_W-1:0]  w_prod, w_rnd;

    logic                      r_out_valid;
    logic signed [COEFF_W-1:0] r_coeff;
    logic [COORD_W-1:0]        r_out_col, r_out_row;
    logic                      r_run_last;

    // Clamp the size registers to the supported range
    always_comb begin
        w_hw = r_half_w;
        if (w_hw > HALF_W'(W_LIM)) w_hw = HALF_W'(W_LIM);
        if (w_hw == '0) w_hw = HALF_W'(1);
        w_hh = r_half_h;
        if (w_hh > HALF_W'(H_LIM)) w_hh = HALF_W'(H_LIM);
        if (w_hh == '0) w_hh = HALF_W'(1);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && r_col[0] && r_row[0]) n_state = S_COMB;
            end
            S_COMB: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_load && (r_k == LAST_K)) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer
    always_comb begin
        w_in_ready = 1'b0;
        w_op_load  = 1'b0;
        w_load     = 1'b0;
        unique case (r_state)
            S_IDLE: w_in_ready = 1'b1;
            S_COMB: w_op_load  = 1'b1;
            S_EMIT: w_load     = !r_out_valid || o_out.ready;
            default: w_in_ready = 1'b0;
        endcase
    end

    assign w_in_acc   = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    // Raster counters
    assign w_col_inc  = CNT_W'(r_col) + CNT_W'(1);
    assign w_col_wrap = w_col_inc >= {w_hw, 1'b0};
    assign w_row_inc  = CNT_W'(r_row) + CNT_W'(1);
    assign w_row_wrap = w_row_inc >= {w_hh, 1'b0};

    // Row pass: pair sum and difference scaled by 1/sqrt(2)
    assign w_add     = (SAMPLE_W + 1)'(r_held) + (SAMPLE_W + 1)'(i_in.sample);
    assign w_sub     = (SAMPLE_W + 1)'(r_held) - (SAMPLE_W + 1)'(i_in.sample);
    assign w_sum_q8  = PAIR_W'(OP_W'(w_add) * OP_W'(SQRT_HALF_Q8));
    assign w_diff_q8 = PAIR_W'(OP_W'(w_sub) * OP_W'(SQRT_HALF_Q8));

    // Pair store: write on even rows, read on odd rows at the pair column
    assign w_pair_end = w_in_acc && r_col[0];
    assign w_ram_we   = w_pair_end && !r_row[0];
    assign w_ram_re   = w_pair_end && r_row[0];
    assign w_addr     = r_col[ADDR_W:1];

    hdw_ram #(
        .WIDTH (STORE_W),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_addr),
        .i_wdata ({w_sum_q8, w_diff_q8}),
        .i_re    (w_ram_re),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_st = w_rdata[STORE_W-1:PAIR_W];
    assign w_dt = w_rdata[PAIR_W-1:0];

    // Control registers: state, sizes, counters, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_half_w    <= HALF_W'(HALF_MAX);
            r_half_h    <= HALF_W'(HALF_MAX);
            r_col       <= '0;
            r_row       <= '0;
            r_held      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes restart the frame
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_HALF_WIDTH:  r_half_w <= i_cfg_data;
                    CFG_HALF_HEIGHT: r_half_h <= i_cfg_data;
                    default:         r_half_w <= r_half_w;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (w_in_acc) begin
                if (!r_col[0]) r_held <= i_in.sample;
                if (w_col_wrap) begin
                    r_col <= '0;
                    r_row <= w_row_wrap ? '0 : w_row_inc[COORD_W-1:0];
                end else begin
                    r_col <= w_col_inc[COORD_W-1:0];
                end
            end

            // Step through the four coefficients of a group
            if (w_op_load) begin
                r_k <= '0;
            end else if (w_load) begin
                r_k <= r_k + KIDX_W'(1);
            end

            // Hold output until taken
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the bottom pair and its coordinates
    always_ff @(posedge i_clk) begin
        if (w_ram_re) begin
            r_sum  <= w_sum_q8;
            r_diff <= w_diff_q8;
            r_i    <= r_col[COORD_W-1:1];
            r_j    <= r_row[COORD_W-1:1];
        end
    end

    // Column pass operands: LL, HL, LH, HH before scaling
    always_ff @(posedge i_clk) begin
        if (w_op_load) begin
            r_op[0] <= OP_W'(w_st) + OP_W'(r_sum);
            r_op[1] <= OP_W'(w_dt) + OP_W'(r_diff);
            r_op[2] <= OP_W'(w_st) - OP_W'(r_sum);
            r_op[3] <= OP_W'(w_dt) - OP_W'(r_diff);
        end
    end

    // Scale by 1/sqrt(2) and round to nearest Q.8
    assign w_prod = PROD_W'(r_op[r_k]) * PROD_W'(SQRT_HALF_Q8);
    assign w_rnd  = w_prod + PROD_W'(ROUND_HALF);

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_coeff    <= w_rnd[FRAC_W+COEFF_W-1:FRAC_W];
            r_out_col  <= COORD_W'(r_i) + (r_k[0] ? w_hw : '0);
            r_out_row  <= COORD_W'(r_j) + (r_k[1] ? w_hh : '0);
            r_run_last <= (r_k == LAST_K);
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.coeff    = r_coeff;
    assign o_out.out_col  = r_out_col;
    assign o_out.out_row  = r_out_row;
    assign o_out.run_last = r_run_last;

`ifndef SYNTHESIS
    // A bottom pair always starts the store read and operand build
    a_fetch_then_comb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && r_col[0] && r_row[0]) |=> (r_state == S_COMB))
        else $error("odd-row pair did not start the column pass");

    // The column counter stays inside the configured width
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W'(r_col) < {w_hw, 1'b0}))
        else $error("column counter beyond image width");

    // The fourth coefficient closes the group and frees the input
    a_group_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_k == LAST_K)) |=> (r_state == S_IDLE && r_run_last))
        else $error("group did not close after the fourth coefficient");
`endif

endmodule

FILE: hdl/hdw_ram.sv
// ============================================================================
// hdw_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ============================================================================
module hdw_ram #(
    parameter int  WIDTH  = 1,
    parameter int  DEPTH  = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
